// ===== src/batched_unitary_similarity_transform_core_macros.svh =====
// Assertion macros shared by the similarity transform core.
`ifndef BATCHED_UNITARY_SIMILARITY_TRANSFORM_CORE_MACROS_SVH
`define BATCHED_UNITARY_SIMILARITY_TRANSFORM_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BUST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define BUST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/bust_pkg.sv =====
// Types and constants shared by the similarity transform core.
package bust_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxWidth = 2;

  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_U = 2'd1,
    CMD_WRITE_L = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_SIZE_N = 2'd0;
  localparam logic [1:0] REG_SIZE_M = 2'd1;
  localparam logic [1:0] REG_LEFT_MODE = 2'd2;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       valid;   // a product term is issued this cycle
    logic       first;   // first term of a dot product
    logic       lastk;   // last term of a dot product
    logic       stage2;  // second product stage
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] slc;
    logic       fin;     // last element of the result run
  } mac_ctl_t;

  // Round a Q16.48 product to Q17.24, halves toward plus infinity.
  function automatic logic signed [40:0] round_prod(input logic signed [63:0] p);
    logic signed [64:0] v;
    begin
      v = 65'(p) + 65'sd8388608;
      round_prod = v[64:24];
    end
  endfunction

  // Saturate a 43-bit sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [42:0] s);
    begin
      if (s > 43'sd2147483647) sat32 = 32'sh7FFFFFFF;
      else if (s < -43'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = s[31:0];
    end
  endfunction
endpackage

// ===== src/bust_seq.sv =====
// Sequencer that walks both product stages of a compute command.
module bust_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         nm1,
  input  logic [1:0]         mm1,
  input  logic               hold,
  output logic               busy,
  output bust_pkg::mac_ctl_t ctl
);
  import bust_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ST1, S_WAIT, S_ST2} state_t;
  state_t state;
  logic [1:0] i, j, k, s;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl.valid = ((state == S_ST1) || (state == S_ST2)) && !hold;
    ctl.first = (k == 2'd0);
    ctl.lastk = (k == nm1);
    ctl.stage2 = (state == S_ST2);
    ctl.row = i;
    ctl.col = j;
    ctl.slc = s;
    ctl.fin = (state == S_ST2) && (i == nm1) && (j == nm1) && (s == mm1) && (k == nm1);
  end

  // Stage one loops slice, row, col, k; stage two loops row, col, slice, k.
  // A wait state between the stages lets the last work write land first.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0; j <= '0; k <= '0; s <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ST1;
            i <= '0; j <= '0; k <= '0; s <= '0;
          end
        end
        S_ST1: begin
          if (k != nm1) k <= k + 2'd1;
          else begin
            k <= '0;
            if (j != nm1) j <= j + 2'd1;
            else begin
              j <= '0;
              if (i != nm1) i <= i + 2'd1;
              else begin
                i <= '0;
                if (s != mm1) s <= s + 2'd1;
                else begin
                  s <= '0;
                  state <= S_WAIT;
                end
              end
            end
          end
        end
        S_WAIT: begin
          if (k != 2'd1) k <= k + 2'd1;
          else begin
            k <= '0;
            state <= S_ST2;
          end
        end
        S_ST2: begin
          if (!hold) begin
            if (k != nm1) k <= k + 2'd1;
            else begin
              k <= '0;
              if (s != mm1) s <= s + 2'd1;
              else begin
                s <= '0;
                if (j != nm1) j <= j + 2'd1;
                else begin
                  j <= '0;
                  if (i != nm1) i <= i + 2'd1;
                  else begin
                    i <= '0;
                    state <= S_IDLE;
                  end
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/bust_datapath.sv =====
// Memories and multiply-accumulate datapath of the similarity transform core.
module bust_datapath #(
  parameter int unsigned MAX_N = 4,
  parameter int unsigned MAX_M = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_cmd,
  input  logic [1:0]         wr_row,
  input  logic [1:0]         wr_col,
  input  logic [1:0]         wr_slc,
  input  logic [31:0]        wr_value,
  input  logic               left_mode,
  input  bust_pkg::mac_ctl_t ctl,
  output logic               res_valid,
  output logic [1:0]         res_row,
  output logic [1:0]         res_col,
  output logic [1:0]         res_slc,
  output logic [31:0]        res_value,
  output logic               res_last
);
  import bust_pkg::*;

  localparam int unsigned MatDepth = MAX_N * MAX_N;
  localparam int unsigned TenDepth = MAX_N * MAX_N * MAX_M;
  localparam int unsigned MatAw = (MatDepth > 1) ? $clog2(MatDepth) : 1;
  localparam int unsigned TenAw = (TenDepth > 1) ? $clog2(TenDepth) : 1;

  logic [31:0] tensor_mem [TenDepth];
  logic [31:0] work_mem [TenDepth];
  logic [31:0] right_mem [MatDepth];
  logic [31:0] left_mem [MatDepth];

  function automatic logic [TenAw-1:0] tidx(input logic [1:0] r, input logic [1:0] c,
                                            input logic [1:0] sl);
    tidx = TenAw'((32'(r) * MAX_N + 32'(c)) * MAX_M + 32'(sl));
  endfunction
  function automatic logic [MatAw-1:0] midx(input logic [1:0] r, input logic [1:0] c);
    midx = MatAw'(32'(r) * MAX_N + 32'(c));
  endfunction

  // Host writes, with out-of-range positions dropped.
  logic wr_ok;
  assign wr_ok = wr_en && (32'(wr_row) < MAX_N) && (32'(wr_col) < MAX_N);
  always_ff @(posedge clk) begin
    if (wr_ok && wr_cmd == CMD_WRITE_A && 32'(wr_slc) < MAX_M)
      tensor_mem[tidx(wr_row, wr_col, wr_slc)] <= wr_value;
    if (wr_ok && wr_cmd == CMD_WRITE_U)
      right_mem[midx(wr_row, wr_col)] <= wr_value;
    if (wr_ok && wr_cmd == CMD_WRITE_L)
      left_mem[midx(wr_row, wr_col)] <= wr_value;
  end

  // Term index counter mirrors the sequencer's k.
  logic [1:0] rd_k;
  always_ff @(posedge clk) begin
    if (rst) rd_k <= '0;
    else if (ctl.valid) rd_k <= ctl.lastk ? 2'd0 : rd_k + 2'd1;
  end

  // Operand addresses for this term.
  logic [TenAw-1:0] ta_addr, wk_addr;
  logic [MatAw-1:0] ra_addr, la_addr;
  logic [1:0] kk;
  always_comb begin
    kk = 2'd0;
    if (ctl.valid) kk = rd_k;
    ta_addr = tidx(kk, ctl.col, ctl.slc);
    wk_addr = tidx(ctl.row, kk, ctl.slc);
    ra_addr = ctl.stage2 ? midx(kk, ctl.col) :
              (left_mode ? midx(kk, ctl.row) : midx(kk, ctl.row));
    la_addr = midx(ctl.row, kk);
  end

  // Registered memory reads, stage one.
  logic [31:0] t_q, w_q, r_q, l_q;
  mac_ctl_t c1;
  logic lm1;
  always_ff @(posedge clk) begin
    t_q <= tensor_mem[ta_addr];
    w_q <= work_mem[wk_addr];
    r_q <= right_mem[ra_addr];
    l_q <= left_mem[la_addr];
    lm1 <= left_mode;
    if (rst) c1 <= '0;
    else c1 <= ctl;
  end

  // Multiply, stage two.
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod;
  mac_ctl_t c2;
  always_comb begin
    if (c1.stage2) begin
      opa = w_q; opb = r_q;
    end else begin
      opa = lm1 ? l_q : r_q; opb = t_q;
    end
  end
  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (rst) c2 <= '0;
    else c2 <= c1;
  end

  // Round and accumulate, stage three.
  logic signed [42:0] acc, acc_next;
  assign acc_next = (c2.first ? 43'sd0 : acc) + 43'(round_prod(prod));
  always_ff @(posedge clk) begin
    if (c2.valid) acc <= acc_next;
  end

  // Write back stage-one sums; emit stage-two sums.
  always_ff @(posedge clk) begin
    if (c2.valid && c2.lastk && !c2.stage2)
      work_mem[tidx(c2.row, c2.col, c2.slc)] <= sat32(acc_next);
  end
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= c2.valid && c2.lastk && c2.stage2;
    res_row <= c2.row;
    res_col <= c2.col;
    res_slc <= c2.slc;
    res_value <= sat32(acc_next);
    res_last <= c2.fin;
  end
endmodule

// ===== src/batched_unitary_similarity_transform_core.sv =====
// Top level of the batched similarity transform core.
//
// Usage: configure size_n, size_m and left_mode over the APB port while
// idle. Send items on the s_axis channel: tdata holds command, row, col,
// slice and value. Write commands store one element each and do not make
// the block busy. A compute command makes the block busy: it walks stage one
// (left factor times each slice of A into the work memory), then stage two
// (work times U), one product term per cycle except while stage two is held, on
// a shared multiplier fed by synchronous memories. Results leave on m_axis with
// tlast on the final element, in row, column, slice order.
// An idle wait state after stage one lets the last work write settle. In stage
// two each element issues its N terms, then holds until its result leaves the
// pipeline, so the input is not ready until the last result of the command has
// left the pipeline. When the receiver stalls, the result register holds and the
// stage-two walk pauses, so nothing is lost; a result still waiting does not block
// the next write item.
// Reset clears control state; memory contents are undefined until written.
// Register reads return the stored configuration values.
module batched_unitary_similarity_transform_core #(
  parameter int unsigned MAX_N = 4,
  parameter int unsigned MAX_M = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [3:2] row, [5:4] col, [7:6] slice, [39:8] value
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] out_row, [3:2] out_col, [5:4] out_slice, [37:6] out_value, [39:38] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bust_pkg::*;
  `include "batched_unitary_similarity_transform_core_macros.svh"

  logic [2:0] size_n, size_m;
  logic left_mode;
  logic [1:0] nm1, mm1;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_n <= 3'd4; size_m <= 3'd4; left_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SIZE_N: size_n <= pwdata[2:0];
        REG_SIZE_M: size_m <= pwdata[2:0];
        REG_LEFT_MODE: left_mode <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_SIZE_N: prdata = {29'd0, size_n};
      REG_SIZE_M: prdata = {29'd0, size_m};
      REG_LEFT_MODE: prdata = {31'd0, left_mode};
      default: prdata = '0;
    endcase
  end

  // Clamp sizes to the supported range, as last indexes.
  always_comb begin
    if (size_n == 3'd0) nm1 = 2'd0;
    else if (32'(size_n) > MAX_N) nm1 = 2'(MAX_N - 1);
    else nm1 = 2'(size_n - 3'd1);
    if (size_m == 3'd0) mm1 = 2'd0;
    else if (32'(size_m) > MAX_M) mm1 = 2'(MAX_M - 1);
    else mm1 = 2'(size_m - 3'd1);
  end

  logic busy, in_xfer, hold, drain;
  mac_ctl_t ctl;
  logic res_valid, res_last;
  logic [1:0] res_row, res_col, res_slc;
  logic [31:0] res_value;
  logic [2:0] inflight;

  assign s_axis_tready = !busy && (inflight == 3'd0);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Pause stage-two issue while the output register is stalled or a result is still in the pipeline.
  assign drain = m_axis_tvalid && !m_axis_tready;
  assign hold = ctl.stage2 && (drain || inflight != 3'd0);

  bust_seq u_seq (
    .clk(clk), .rst(rst),
    .start(in_xfer && s_axis_tdata[1:0] == CMD_COMPUTE),
    .nm1(nm1), .mm1(mm1), .hold(hold), .busy(busy), .ctl(ctl)
  );

  bust_datapath #(.MAX_N(MAX_N), .MAX_M(MAX_M)) u_dp (
    .clk(clk), .rst(rst),
    .wr_en(in_xfer && s_axis_tdata[1:0] != CMD_COMPUTE),
    .wr_cmd(s_axis_tdata[1:0]), .wr_row(s_axis_tdata[3:2]),
    .wr_col(s_axis_tdata[5:4]), .wr_slc(s_axis_tdata[7:6]),
    .wr_value(s_axis_tdata[39:8]), .left_mode(left_mode), .ctl(ctl),
    .res_valid(res_valid), .res_row(res_row), .res_col(res_col),
    .res_slc(res_slc), .res_value(res_value), .res_last(res_last)
  );

  // Count stage-two final terms in the pipeline.
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + 3'(ctl.valid && ctl.stage2 && ctl.lastk)
                     - 3'(res_valid);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (res_valid) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (res_valid) begin
      m_axis_tdata <= {2'b00, res_value, res_slc, res_col, res_row};
      m_axis_tlast <= res_last;
    end
  end

  `BUST_ASSERT_IMP(a_no_overrun, clk, rst, res_valid, !drain, "result overran output")
  `BUST_ASSERT_IMP(a_busy_no_in, clk, rst, busy, !s_axis_tready, "input taken while busy")
  `BUST_ASSERT_NEXT(a_out_hold, clk, rst, drain, m_axis_tvalid, "stalled result dropped")
endmodule
